/* src/similarity_point_transform_defines.svh */
// ----------------------------------------------------------------------------
// Similarity point transform assertion macros
// Shared assertion forms for the point transform RTL. They expect signals
// named clk and rst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SIMILARITY_POINT_TRANSFORM_DEFINES_SVH
`define SIMILARITY_POINT_TRANSFORM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/spt_pkg.sv */
// ----------------------------------------------------------------------------
// Similarity point transform package
// Widths, register indexes and pipeline record types of the point transform.
// ----------------------------------------------------------------------------
package spt_pkg;

  // Field widths.
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned QUAT_W     = 16;
  localparam int unsigned SHIFT_W    = 32;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 3 * COORD_W;

  // Datapath widths.
  localparam int unsigned QPROD_W    = 2 * QUAT_W;
  localparam int unsigned MAT_W      = 34;
  localparam int unsigned OPD_W      = COORD_W + SCALE_W + 1;
  localparam int unsigned LO_A_W     = 28;
  localparam int unsigned LO_M_W     = 17;
  localparam int unsigned HI_A_W     = OPD_W - LO_A_W;
  localparam int unsigned HI_M_W     = MAT_W - LO_M_W;
  localparam int unsigned PROD_W     = 91;
  localparam int unsigned FRAC_SHIFT = 44;
  localparam int unsigned DEN_SHIFT  = 12;
  localparam int unsigned DIV_W      = SCALE_W + DEN_SHIFT;
  localparam int unsigned NUM_W      = 68;
  localparam int unsigned QUO_W      = COORD_W + 1;

  // Pipeline: input, operand, partial products, products, sums, divider init
  // and one divider stage per quotient bit.
  localparam int unsigned PIPE_STAGES = 5 + QUO_W + 1;
  localparam logic [1:0]  SETTLE_CYCLES = 2'd2;

  localparam logic signed [MAT_W-1:0] ONE_Q28 = MAT_W'(1) << 28;
  localparam logic [PROD_W:0]         ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_SHIFT - 1);
  localparam logic [QUO_W-1:0]        BOUND_POS = QUO_W'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam logic [QUO_W-1:0]        BOUND_NEG = QUO_W'(64'd1 << (COORD_W - 1));

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_W   = 3'd0,
    REG_ROT_X   = 3'd1,
    REG_ROT_Y   = 3'd2,
    REG_ROT_Z   = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6,
    REG_SCALE   = 3'd7
  } cfg_reg_t;

  // One coordinate in the divider pipeline.
  typedef struct packed {
    logic             neg;
    logic             pre_ovf;
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] nq;
  } div_lane_t;

  // One divider stage: shared divisor and three coordinates.
  typedef struct packed {
    logic [DIV_W-1:0] den;
    div_lane_t [2:0]  lane;
  } div_stage_t;

  // Finished result item.
  typedef struct packed {
    logic                 ovf;
    logic [IN_DATA_W-1:0] coords;
  } result_t;

endpackage

/* src/similarity_point_transform.sv */
// ----------------------------------------------------------------------------
// Similarity point transform
// Applies a scale, quaternion rotation and translation to 3D points, or the
// inverse of that transform, with rounding and saturation.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle while in_tready is high, and
// passes each accepted point through an input register, five arithmetic
// stages (operand, partial products, products, sums, rounding setup), then a
// restoring divider with one stage per quotient bit, then the output register.
// Inverse mode divides by the scale in that divider; forward mode passes
// through it with a divisor of one. A skid register behind the output lets
// the input keep flowing while one result waits. After any configuration
// write the input is held off while the rotation matrix is rebuilt from the
// quaternion, first its products and then the matrix.
`include "similarity_point_transform_defines.svh"

module similarity_point_transform (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input points.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [spt_pkg::IN_DATA_W-1:0]    in_tdata,   // point_x, point_y, point_z
  input  logic [0:0]                       in_tuser,   // mode
  // Results.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [spt_pkg::IN_DATA_W-1:0]    out_tdata,  // out_x, out_y, out_z
  output logic [0:0]                       out_tuser,  // overflow
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers and matrix.
  logic signed [spt_pkg::QUAT_W-1:0]  rot_w_r, rot_x_r, rot_y_r, rot_z_r;
  logic signed [spt_pkg::SHIFT_W-1:0] shift_r [3];
  logic [spt_pkg::SCALE_W-1:0]        scale_r;
  logic [1:0]                         settle_r;
  logic signed [spt_pkg::QPROD_W-1:0] qxx_r, qyy_r, qzz_r, qxy_r, qwz_r;
  logic signed [spt_pkg::QPROD_W-1:0] qxz_r, qwy_r, qyz_r, qwx_r;
  logic signed [spt_pkg::MAT_W-1:0]   mat_r [3][3];

  // Pipeline control.
  logic                               en;
  logic                               in_acc;
  logic [spt_pkg::PIPE_STAGES-1:0]    pipe_v_r;

  // Pipeline payload.
  logic                               s0_mode_r, s1_mode_r, s2_mode_r, s3_mode_r, s4_mode_r;
  logic signed [spt_pkg::COORD_W-1:0] s0_pt_r [3];
  logic signed [spt_pkg::OPD_W-1:0]   s1_a_r [3];
  logic signed [spt_pkg::OPD_W-1:0]   s1_a_nxt [3];
  logic [spt_pkg::LO_A_W+spt_pkg::LO_M_W-1:0]       pp_ll_r [3][3], pp_ll_nxt [3][3];
  logic signed [spt_pkg::LO_A_W+spt_pkg::HI_M_W:0]  pp_lh_r [3][3], pp_lh_nxt [3][3];
  logic signed [spt_pkg::HI_A_W+spt_pkg::LO_M_W:0]  pp_hl_r [3][3], pp_hl_nxt [3][3];
  logic signed [spt_pkg::HI_A_W+spt_pkg::HI_M_W-1:0] pp_hh_r [3][3], pp_hh_nxt [3][3];
  logic signed [spt_pkg::PROD_W-1:0]  prod_r [3][3], prod_nxt [3][3];
  logic signed [spt_pkg::PROD_W-1:0]  sum_r [3], sum_nxt [3];
  spt_pkg::div_stage_t                dv_init_nxt;
  spt_pkg::div_stage_t                dv_r [spt_pkg::QUO_W+1];
  spt_pkg::div_stage_t                dv_nxt [spt_pkg::QUO_W+1];

  // Output and skid registers.
  spt_pkg::result_t                   res_nxt;
  spt_pkg::result_t                   out_res_r, skid_res_r;
  logic                               out_valid_r, skid_full_r;

  // Configuration port: always ready, writes hold off input until the matrix settles.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_w_r    <= spt_pkg::QUAT_W'(16384);
      rot_x_r    <= '0;
      rot_y_r    <= '0;
      rot_z_r    <= '0;
      shift_r[0] <= '0;
      shift_r[1] <= '0;
      shift_r[2] <= '0;
      scale_r    <= spt_pkg::SCALE_W'(65536);
      settle_r   <= '0;
    end else begin
      if (cfg_valid) begin
        settle_r <= spt_pkg::SETTLE_CYCLES;
        unique case (spt_pkg::cfg_reg_t'(cfg_index))
          spt_pkg::REG_ROT_W:   rot_w_r    <= cfg_data[spt_pkg::QUAT_W-1:0];
          spt_pkg::REG_ROT_X:   rot_x_r    <= cfg_data[spt_pkg::QUAT_W-1:0];
          spt_pkg::REG_ROT_Y:   rot_y_r    <= cfg_data[spt_pkg::QUAT_W-1:0];
          spt_pkg::REG_ROT_Z:   rot_z_r    <= cfg_data[spt_pkg::QUAT_W-1:0];
          spt_pkg::REG_SHIFT_X: shift_r[0] <= cfg_data[spt_pkg::SHIFT_W-1:0];
          spt_pkg::REG_SHIFT_Y: shift_r[1] <= cfg_data[spt_pkg::SHIFT_W-1:0];
          spt_pkg::REG_SHIFT_Z: shift_r[2] <= cfg_data[spt_pkg::SHIFT_W-1:0];
          spt_pkg::REG_SCALE:   scale_r    <= cfg_data[spt_pkg::SCALE_W-1:0];
        endcase
      end else if (settle_r != '0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // Quaternion products, then the rotation matrix in Q.28.
  always_ff @(posedge clk) begin
    qxx_r <= rot_x_r * rot_x_r;
    qyy_r <= rot_y_r * rot_y_r;
    qzz_r <= rot_z_r * rot_z_r;
    qxy_r <= rot_x_r * rot_y_r;
    qwz_r <= rot_w_r * rot_z_r;
    qxz_r <= rot_x_r * rot_z_r;
    qwy_r <= rot_w_r * rot_y_r;
    qyz_r <= rot_y_r * rot_z_r;
    qwx_r <= rot_w_r * rot_x_r;
    mat_r[0][0] <= spt_pkg::ONE_Q28 -
                   ((spt_pkg::MAT_W'(qyy_r) + spt_pkg::MAT_W'(qzz_r)) <<< 1);
    mat_r[0][1] <= (spt_pkg::MAT_W'(qxy_r) - spt_pkg::MAT_W'(qwz_r)) <<< 1;
    mat_r[0][2] <= (spt_pkg::MAT_W'(qxz_r) + spt_pkg::MAT_W'(qwy_r)) <<< 1;
    mat_r[1][0] <= (spt_pkg::MAT_W'(qxy_r) + spt_pkg::MAT_W'(qwz_r)) <<< 1;
    mat_r[1][1] <= spt_pkg::ONE_Q28 -
                   ((spt_pkg::MAT_W'(qxx_r) + spt_pkg::MAT_W'(qzz_r)) <<< 1);
    mat_r[1][2] <= (spt_pkg::MAT_W'(qyz_r) - spt_pkg::MAT_W'(qwx_r)) <<< 1;
    mat_r[2][0] <= (spt_pkg::MAT_W'(qxz_r) - spt_pkg::MAT_W'(qwy_r)) <<< 1;
    mat_r[2][1] <= (spt_pkg::MAT_W'(qyz_r) + spt_pkg::MAT_W'(qwx_r)) <<< 1;
    mat_r[2][2] <= spt_pkg::ONE_Q28 -
                   ((spt_pkg::MAT_W'(qxx_r) + spt_pkg::MAT_W'(qyy_r)) <<< 1);
  end

  // The whole pipeline moves while the skid register is free.
  assign en        = !skid_full_r;
  assign in_tready = en && (settle_r == '0);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r <= '0;
    end else if (en) begin
      pipe_v_r <= {pipe_v_r[spt_pkg::PIPE_STAGES-2:0], in_acc};
    end
  end

  // Operand stage: scaled point, or point minus translation.
  always_comb begin
    logic signed [spt_pkg::OPD_W-1:0] pt_ext;
    logic signed [spt_pkg::OPD_W-1:0] sh_ext;
    logic signed [spt_pkg::OPD_W-1:0] sc_ext;
    for (int k = 0; k < 3; k++) begin
      pt_ext = spt_pkg::OPD_W'(s0_pt_r[k]);
      sh_ext = spt_pkg::OPD_W'(shift_r[k]);
      sc_ext = spt_pkg::OPD_W'($signed({1'b0, scale_r}));
      s1_a_nxt[k] = s0_mode_r ? (pt_ext - sh_ext) : (pt_ext * sc_ext);
    end
  end

  // Partial products of operand times matrix (transposed in inverse mode).
  always_comb begin
    logic signed [spt_pkg::MAT_W-1:0]    m;
    logic signed [spt_pkg::OPD_W-1:0]    a;
    logic [spt_pkg::LO_A_W-1:0]          al;
    logic signed [spt_pkg::HI_A_W-1:0]   ah;
    logic [spt_pkg::LO_M_W-1:0]          ml;
    logic signed [spt_pkg::HI_M_W-1:0]   mh;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m  = s1_mode_r ? mat_r[j][i] : mat_r[i][j];
        a  = s1_a_r[j];
        al = a[spt_pkg::LO_A_W-1:0];
        ah = a[spt_pkg::OPD_W-1:spt_pkg::LO_A_W];
        ml = m[spt_pkg::LO_M_W-1:0];
        mh = m[spt_pkg::MAT_W-1:spt_pkg::LO_M_W];
        pp_ll_nxt[i][j] = al * ml;
        pp_lh_nxt[i][j] = $signed({1'b0, al}) * mh;
        pp_hl_nxt[i][j] = ah * $signed({1'b0, ml});
        pp_hh_nxt[i][j] = ah * mh;
      end
    end
  end

  // Full products from the partial products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] =
          (spt_pkg::PROD_W'(pp_hh_r[i][j]) <<< (spt_pkg::LO_A_W + spt_pkg::LO_M_W)) +
          (spt_pkg::PROD_W'(pp_hl_r[i][j]) <<< spt_pkg::LO_A_W) +
          (spt_pkg::PROD_W'(pp_lh_r[i][j]) <<< spt_pkg::LO_M_W) +
          $signed(spt_pkg::PROD_W'(pp_ll_r[i][j]));
      end
    end
  end

  // Row sums; forward mode adds the translation in Q.44.
  always_comb begin
    logic signed [spt_pkg::PROD_W-1:0] tr;
    for (int i = 0; i < 3; i++) begin
      tr = s3_mode_r ? '0 : (spt_pkg::PROD_W'(shift_r[i]) <<< spt_pkg::FRAC_SHIFT);
      sum_nxt[i] = prod_r[i][0] + prod_r[i][1] + prod_r[i][2] + tr;
    end
  end

  // Rounding setup: magnitude plus half divisor, divider initial remainder.
  always_comb begin
    logic [spt_pkg::PROD_W-1:0]  mag;
    logic [spt_pkg::PROD_W:0]    rnd;
    logic [spt_pkg::NUM_W-1:0]   num;
    logic [spt_pkg::DIV_W-1:0]   den;
    logic [spt_pkg::SCALE_W-1:0] sc_nz;
    logic                        neg;
    sc_nz = (scale_r == '0) ? spt_pkg::SCALE_W'(1) : scale_r;
    den   = s4_mode_r ? {sc_nz, {spt_pkg::DEN_SHIFT{1'b0}}} : spt_pkg::DIV_W'(1);
    dv_init_nxt.den = den;
    for (int l = 0; l < 3; l++) begin
      neg = sum_r[l][spt_pkg::PROD_W-1];
      mag = neg ? (spt_pkg::PROD_W'(0) - sum_r[l]) : sum_r[l];
      rnd = {1'b0, mag} + spt_pkg::ROUND_HALF;
      if (s4_mode_r) begin
        num = spt_pkg::NUM_W'(mag) + spt_pkg::NUM_W'(den >> 1);
      end else begin
        num = spt_pkg::NUM_W'(rnd >> spt_pkg::FRAC_SHIFT);
      end
      dv_init_nxt.lane[l].neg     = neg;
      dv_init_nxt.lane[l].pre_ovf = (num >> spt_pkg::QUO_W) >= spt_pkg::NUM_W'(den);
      dv_init_nxt.lane[l].rem     = spt_pkg::DIV_W'(num >> spt_pkg::QUO_W);
      dv_init_nxt.lane[l].nq      = num[spt_pkg::QUO_W-1:0];
    end
  end

  // Restoring divider, one quotient bit per stage.
  always_comb begin
    logic [spt_pkg::DIV_W:0] sh;
    logic                    ge;
    dv_nxt[0] = dv_init_nxt;
    for (int k = 1; k <= spt_pkg::QUO_W; k++) begin
      dv_nxt[k].den = dv_r[k-1].den;
      for (int l = 0; l < 3; l++) begin
        sh = {dv_r[k-1].lane[l].rem, dv_r[k-1].lane[l].nq[spt_pkg::QUO_W-1]};
        ge = sh >= {1'b0, dv_r[k-1].den};
        dv_nxt[k].lane[l].neg     = dv_r[k-1].lane[l].neg;
        dv_nxt[k].lane[l].pre_ovf = dv_r[k-1].lane[l].pre_ovf;
        dv_nxt[k].lane[l].rem     = ge ? spt_pkg::DIV_W'(sh - {1'b0, dv_r[k-1].den})
                                       : spt_pkg::DIV_W'(sh);
        dv_nxt[k].lane[l].nq      = {dv_r[k-1].lane[l].nq[spt_pkg::QUO_W-2:0], ge};
      end
    end
  end

  // Saturation and sign of the final quotients.
  always_comb begin
    logic [spt_pkg::QUO_W-1:0] bound;
    logic [spt_pkg::QUO_W-1:0] qc;
    logic                      ovf;
    logic                      any_ovf;
    any_ovf = 1'b0;
    res_nxt.coords = '0;
    for (int l = 0; l < 3; l++) begin
      bound = dv_r[spt_pkg::QUO_W].lane[l].neg ? spt_pkg::BOUND_NEG : spt_pkg::BOUND_POS;
      ovf   = dv_r[spt_pkg::QUO_W].lane[l].pre_ovf || (dv_r[spt_pkg::QUO_W].lane[l].nq > bound);
      qc    = ovf ? bound : dv_r[spt_pkg::QUO_W].lane[l].nq;
      any_ovf = any_ovf | ovf;
      res_nxt.coords[l*spt_pkg::COORD_W +: spt_pkg::COORD_W] =
        dv_r[spt_pkg::QUO_W].lane[l].neg ? (spt_pkg::COORD_W'(0) - qc[spt_pkg::COORD_W-1:0])
                                         : qc[spt_pkg::COORD_W-1:0];
    end
    res_nxt.ovf = any_ovf;
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      s0_mode_r <= in_tuser[0];
      s1_mode_r <= s0_mode_r;
      s2_mode_r <= s1_mode_r;
      s3_mode_r <= s2_mode_r;
      s4_mode_r <= s3_mode_r;
      for (int k = 0; k < 3; k++) begin
        s0_pt_r[k] <= in_tdata[k*spt_pkg::COORD_W +: spt_pkg::COORD_W];
        s1_a_r[k]  <= s1_a_nxt[k];
        sum_r[k]   <= sum_nxt[k];
        for (int j = 0; j < 3; j++) begin
          pp_ll_r[k][j] <= pp_ll_nxt[k][j];
          pp_lh_r[k][j] <= pp_lh_nxt[k][j];
          pp_hl_r[k][j] <= pp_hl_nxt[k][j];
          pp_hh_r[k][j] <= pp_hh_nxt[k][j];
          prod_r[k][j]  <= prod_nxt[k][j];
        end
      end
      for (int k = 0; k <= spt_pkg::QUO_W; k++) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (out_valid_r && !out_tready) begin
      if (en && pipe_v_r[spt_pkg::PIPE_STAGES-1]) begin
        skid_full_r <= 1'b1;
      end
    end else if (skid_full_r) begin
      out_valid_r <= 1'b1;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= en && pipe_v_r[spt_pkg::PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_tready) begin
      if (en) begin
        skid_res_r <= res_nxt;
      end
    end else if (skid_full_r) begin
      out_res_r <= skid_res_r;
    end else begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.coords;
  assign out_tuser  = out_res_r.ovf;

  // Checks on the pipeline and output control.
  `SPT_ASSERT_SAME(a_skid_behind_out, skid_full_r, out_valid_r,
                   "skid holds a result while the output register is empty")
  `SPT_ASSERT_NEXT(a_cfg_holds_input, cfg_valid, !in_tready,
                   "input accepted right after a configuration write")
  `SPT_ASSERT_NEXT(a_skid_kept, skid_full_r && !out_tready, skid_full_r,
                   "skid entry lost while the output is stalled")
  `SPT_ASSERT_NEXT(a_last_stage_lands, pipe_v_r[spt_pkg::PIPE_STAGES-1] && en, out_valid_r,
                   "finished transaction did not reach the output")

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Similarity point transform testbench
// Streams points through the transform in both modes under several register
// settings, with random idle cycles on both sides and one long output stall.
// Each result is checked against a bit-exact fixed-point prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import spt_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT  = 2000000;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               ovf;
  } point_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [0:0]            in_tuser;   // mode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [IN_DATA_W-1:0]  out_tdata;  // out_x, out_y, out_z
  logic [0:0]            out_tuser;  // overflow
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the transform registers.
  logic signed [QUAT_W-1:0]  quat_w, quat_x, quat_y, quat_z;
  logic signed [SHIFT_W-1:0] offset_x, offset_y, offset_z;
  logic [SCALE_W-1:0]        scale_q;

  point_result_t expected_points[$];
  int unsigned   error_count;
  int unsigned   cycle_count;
  int unsigned   stall_cycles;
  bit            steady_flow;

  similarity_point_transform dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bit-exact transform of one point with the current register copy.
  function automatic point_result_t transform_point(logic mode, logic [COORD_W-1:0] px,
                                                    logic [COORD_W-1:0] py,
                                                    logic [COORD_W-1:0] pz);
    logic signed [127:0] qw, qx, qy, qz, unity, sc, den, mag, quo, bound;
    logic signed [127:0] rot[3][3];
    logic signed [127:0] pt[3];
    logic signed [127:0] off[3];
    logic signed [127:0] acc[3];
    logic signed [COORD_W-1:0] pin[3];
    logic [COORD_W-1:0] coord[3];
    point_result_t res;
    logic neg;
    qw = quat_w;
    qx = quat_x;
    qy = quat_y;
    qz = quat_z;
    unity = 128'sd1 <<< 28;
    rot[0][0] = unity - 2 * (qy * qy + qz * qz);
    rot[0][1] = 2 * (qx * qy - qw * qz);
    rot[0][2] = 2 * (qx * qz + qw * qy);
    rot[1][0] = 2 * (qx * qy + qw * qz);
    rot[1][1] = unity - 2 * (qx * qx + qz * qz);
    rot[1][2] = 2 * (qy * qz - qw * qx);
    rot[2][0] = 2 * (qx * qz - qw * qy);
    rot[2][1] = 2 * (qy * qz + qw * qx);
    rot[2][2] = unity - 2 * (qx * qx + qy * qy);
    off[0] = offset_x;
    off[1] = offset_y;
    off[2] = offset_z;
    sc = {104'd0, scale_q};
    pin[0] = px;
    pin[1] = py;
    pin[2] = pz;
    res.ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pt[i] = pin[i];
      pt[i] = mode ? pt[i] - off[i] : pt[i] * sc;
    end
    // Forward uses the matrix, inverse its transpose.
    for (int i = 0; i < 3; i++) begin
      acc[i] = mode ? 128'sd0 : off[i] <<< FRAC_SHIFT;
      for (int j = 0; j < 3; j++)
        acc[i] = acc[i] + pt[j] * (mode ? rot[j][i] : rot[i][j]);
    end
    // A zero scale counts as one LSB in inverse mode.
    if (mode) begin
      den = ((sc == 0) ? 128'sd1 : sc) <<< DEN_SHIFT;
    end else begin
      den = 128'sd1 <<< FRAC_SHIFT;
    end
    // Round to nearest with ties away from zero, then saturate.
    for (int i = 0; i < 3; i++) begin
      neg = acc[i][127];
      mag = neg ? -acc[i] : acc[i];
      quo = (mag + (den >>> 1)) / den;
      bound = neg ? (128'sd1 <<< (COORD_W - 1)) : (128'sd1 <<< (COORD_W - 1)) - 1;
      if (quo > bound) begin
        quo = bound;
        res.ovf = 1'b1;
      end
      if (neg) quo = -quo;
      coord[i] = quo[COORD_W-1:0];
    end
    res.x = coord[0];
    res.y = coord[1];
    res.z = coord[2];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [COORD_W-1:0] got,
                                 logic [COORD_W-1:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // One register write transaction, applied to the shadow copy on acceptance.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROT_W:   quat_w   = value[QUAT_W-1:0];
      REG_ROT_X:   quat_x   = value[QUAT_W-1:0];
      REG_ROT_Y:   quat_y   = value[QUAT_W-1:0];
      REG_ROT_Z:   quat_z   = value[QUAT_W-1:0];
      REG_SHIFT_X: offset_x = value;
      REG_SHIFT_Y: offset_y = value;
      REG_SHIFT_Z: offset_z = value;
      REG_SCALE:   scale_q  = value[SCALE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z,
                           logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                           logic [23:0] s);
    write_reg(REG_ROT_W, 32'(w));
    write_reg(REG_ROT_X, 32'(x));
    write_reg(REG_ROT_Y, 32'(y));
    write_reg(REG_ROT_Z, 32'(z));
    write_reg(REG_SHIFT_X, tx);
    write_reg(REG_SHIFT_Y, ty);
    write_reg(REG_SHIFT_Z, tz);
    write_reg(REG_SCALE, 32'(s));
  endtask

  // Offers one point, with random idle cycles ahead of it, and waits for acceptance.
  task automatic send_point(logic mode, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                            logic [COORD_W-1:0] pz);
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pz, py, px};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    expected_points.push_back(transform_point(mode, px, py, pz));
  endtask

  task automatic end_stream();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Waits for every result, then for the pipeline to settle.
  task automatic drain();
    end_stream();
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(2000000)) - 1000000);
      2:       return 32'($signed($urandom_range(20000000)) - 10000000);
      default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic logic signed [15:0] rand_quat();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // Identity setting, then a rotation, with the coordinate extremes.
  task automatic test_directed_extremes();
    logic [31:0] corner[5];
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000};
    steady_flow = 1'b1;
    for (int m = 0; m < 2; m++)
      for (int k = 0; k < 5; k++)
        send_point(m[0], corner[k], corner[(k + 1) % 5], corner[(k + 3) % 5]);
    drain();
    // Quarter turn about z, doubled scale, shifted: forward saturates high values.
    write_all(16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 32'h0003_0000, 32'hFFFF_8000,
              32'h7FFF_FFFF, 24'd131072);
    for (int m = 0; m < 2; m++)
      for (int k = 0; k < 5; k++)
        send_point(m[0], corner[k], corner[(k + 2) % 5], corner[(k + 4) % 5]);
    drain();
    steady_flow = 1'b0;
  endtask

  // Extreme register settings, each with a short burst of points.
  task automatic test_register_extremes();
    write_all(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 24'd1);
    for (int k = 0; k < 20; k++) send_point($urandom_range(1), rand_coord(), rand_coord(),
                                            rand_coord());
    drain();
    write_all(16'sd16384, -16'sd16384, 16'sd0, -16'sd16384, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h0000_0001, 24'hFF_FFFF);
    for (int k = 0; k < 20; k++) send_point($urandom_range(1), rand_coord(), rand_coord(),
                                            rand_coord());
    drain();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_stall();
    write_all(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 32'd0, 32'd0, 32'd0, 24'd65536);
    steady_flow = 1'b1;
    stall_cycles = 200;
    for (int k = 0; k < 80; k++) send_point($urandom_range(1), rand_coord(), rand_coord(),
                                            rand_coord());
    steady_flow = 1'b0;
    drain();
  endtask

  // Random settings, each followed by a burst of random points.
  task automatic test_random_points();
    logic [23:0] s;
    for (int ph = 0; ph < 6; ph++) begin
      s = ($urandom_range(1) != 0) ? 24'($urandom_range(16777215, 1))
                                   : 24'($urandom_range(200000, 20000));
      write_all(rand_quat(), rand_quat(), rand_quat(), rand_quat(), rand_coord(),
                rand_coord(), rand_coord(), s);
      steady_flow = (ph == 2);
      for (int k = 0; k < 105; k++)
        send_point($urandom_range(1), rand_coord(), rand_coord(), rand_coord());
      steady_flow = 1'b0;
      drain();
    end
  endtask

  // Receiver side: random idling, plus a counted hold-off on request.
  always @(negedge clk) begin
    if (stall_cycles != 0) begin
      out_tready <= 1'b0;
      stall_cycles <= stall_cycles - 1;
    end else begin
      out_tready <= steady_flow || ($urandom_range(99) >= 12);
    end
  end

  // Compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    point_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], '0);
      end else begin
        want = expected_points.pop_front();
        if (out_tdata[31:0] !== want.x) report_mismatch("out_x", out_tdata[31:0], want.x);
        if (out_tdata[63:32] !== want.y) report_mismatch("out_y", out_tdata[63:32], want.y);
        if (out_tdata[95:64] !== want.z) report_mismatch("out_z", out_tdata[95:64], want.z);
        if (out_tuser[0] !== want.ovf)
          report_mismatch("overflow", 32'(out_tuser[0]), 32'(want.ovf));
      end
    end
  end

  // Guards against a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    cycle_count = 0;
    stall_cycles = 0;
    steady_flow = 1'b0;
    quat_w = 16'sd16384;
    quat_x = '0;
    quat_y = '0;
    quat_z = '0;
    offset_x = '0;
    offset_y = '0;
    offset_z = '0;
    scale_q = 24'd65536;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_extremes();
    test_register_extremes();
    test_output_stall();
    test_random_points();

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/spt_pkg.sv
src/similarity_point_transform.sv
sim/tb_top.sv
